### sv/dtl_pkg.sv
// shared types and constants of the token lexer
package dtl_pkg;

  // token kinds as they leave the block
  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_SYMBOL  = 3'd2,
    KIND_LITERAL = 3'd3,
    KIND_END     = 3'd4
  } token_kind_e;

  // scanner mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_DIGITS = 4'b0010,
    MODE_WORD   = 4'b0100,
    MODE_WORD_N = 4'b1000
  } scan_mode_e;

  localparam int unsigned CFG_W        = 16;
  localparam int unsigned TOK_PER_BYTE = 3;
  localparam int unsigned FIFO_DEPTH   = 8;
  localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam logic [CFG_W-1:0] FIRST_LINE_RST = 16'd1;

  localparam int unsigned NUM_KW = 8;
  localparam int unsigned KW_MAX = 16;

  // keyword text, right aligned: last character in the low byte
  localparam logic [8*KW_MAX-1:0] KW_STR [NUM_KW] = '{
    "Index", "Participant", "Channel", "Label",
    "foreach", "end", "min", "max"
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd5, 4'd11, 4'd7, 4'd5, 4'd7, 4'd3, 4'd3, 4'd3
  };

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // character of keyword k at offset i (i below the keyword length)
  function automatic logic [7:0] kw_char(int unsigned k, logic [3:0] i);
    logic [3:0] sel;
    sel = KW_LEN[k] - 4'd1 - i;
    return KW_STR[k][{sel, 3'b000} +: 8];
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_sym(logic [7:0] b);
    return (b == "{") || (b == "}") || (b == "<") || (b == ">") || (b == "[") ||
           (b == "]") || (b == "(") || (b == ")") || (b == ".") || (b == "=") ||
           (b == "+") || (b == "-") || (b == ":");
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // drop keywords that cannot match once byte b sits at offset idx
  function automatic logic [NUM_KW-1:0] narrow(logic [NUM_KW-1:0] cand, logic [3:0] idx,
                                               logic idx_big, logic [7:0] b);
    logic [NUM_KW-1:0] res;
    res = cand;
    for (int unsigned k = 0; k < NUM_KW; k++) begin
      if (idx_big || (idx >= KW_LEN[k]) || (kw_char(k, idx) != b)) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

endpackage

### sv/dtl_if.sv
// handshake channels of the token lexer: text in, tokens out, configuration
interface dtl_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface dtl_token_if #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned LINE_BITS     = 16
);
  logic                     valid;
  logic                     ready;
  logic [2:0]               token_kind;
  logic [POSITION_BITS-1:0] token_start;
  logic [POSITION_BITS-1:0] token_length;
  logic [LINE_BITS-1:0]     token_line;
  logic                     run_last;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output token_line, output run_last, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input token_line, input run_last, output ready);
endinterface

interface dtl_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_line;

  modport source (output valid, output first_line, input ready);
  modport sink (input valid, input first_line, output ready);
endinterface

### sv/dsl_token_lexer.sv
// Streaming lexer: takes one source byte per cycle and returns its tokens (kind, start offset,
// length, line), one token per cycle on the output channel. A byte is taken in every cycle
// while the eight-entry token queue has room for three more tokens; a byte yields zero to
// three tokens, so sustained input rate is one byte a cycle whenever the output keeps pace
// with the tokens produced, and the output channel (one token a cycle) sets the pace otherwise.
// Tokens enter the token queue, in order, when the byte that completes them is taken. The
// first_line register is always ready and is used from the first byte of the next text on.
module dsl_token_lexer import dtl_pkg::*; #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned LINE_BITS     = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dtl_cfg_if.sink           cfg_i,
  dtl_text_if.sink          text_i,
  dtl_token_if.source       token_o
);

  logic                     fire;
  logic                     space;
  logic [1:0]               push_cnt;
  token_kind_e              tok_kind   [TOK_PER_BYTE];
  logic [POSITION_BITS-1:0] tok_start  [TOK_PER_BYTE];
  logic [POSITION_BITS-1:0] tok_length [TOK_PER_BYTE];
  logic [LINE_BITS-1:0]     tok_line   [TOK_PER_BYTE];

  assign cfg_i.ready  = 1'b1;
  assign text_i.ready = space;
  assign fire         = text_i.valid && space;

  dtl_scan_core #(
    .POSITION_BITS (POSITION_BITS),
    .LINE_BITS     (LINE_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.first_line),
    .fire_i       (fire),
    .byte_i       (text_i.text_byte),
    .last_i       (text_i.final_byte),
    .push_cnt_o   (push_cnt),
    .tok_kind_o   (tok_kind),
    .tok_start_o  (tok_start),
    .tok_length_o (tok_length),
    .tok_line_o   (tok_line)
  );

  dtl_token_fifo #(
    .POSITION_BITS (POSITION_BITS),
    .LINE_BITS     (LINE_BITS)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cnt_i   (push_cnt),
    .tok_kind_i   (tok_kind),
    .tok_start_i  (tok_start),
    .tok_length_i (tok_length),
    .tok_line_i   (tok_line),
    .space_o      (space),
    .out_valid_o  (token_o.valid),
    .out_ready_i  (token_o.ready),
    .out_kind_o   (token_o.token_kind),
    .out_start_o  (token_o.token_start),
    .out_length_o (token_o.token_length),
    .out_line_o   (token_o.token_line),
    .out_last_o   (token_o.run_last)
  );

endmodule

### sv/dtl_scan_core.sv
// scanner state and the per-byte token decision, up to three tokens a byte
module dtl_scan_core import dtl_pkg::*; #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned LINE_BITS     = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     fire_i,
  input  logic [7:0]               byte_i,
  input  logic                     last_i,
  output logic [1:0]               push_cnt_o,
  output token_kind_e              tok_kind_o   [TOK_PER_BYTE],
  output logic [POSITION_BITS-1:0] tok_start_o  [TOK_PER_BYTE],
  output logic [POSITION_BITS-1:0] tok_length_o [TOK_PER_BYTE],
  output logic [LINE_BITS-1:0]     tok_line_o   [TOK_PER_BYTE]
);

  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] POS_TWO = POSITION_BITS'(2);

  logic [CFG_W-1:0]         first_line_q;
  logic [LINE_BITS-1:0]     first_sat;
  scan_mode_e               mode_q, mode_d;
  logic [POSITION_BITS-1:0] ws_q, ws_d;
  logic [POSITION_BITS-1:0] wl_q, wl_d;
  logic [NUM_KW-1:0]        cand_q, cand_d;
  logic                     pm_q, pm_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [LINE_BITS-1:0]     ln_q, ln_d;

  // register value clipped to the line range
  if (LINE_BITS >= CFG_W) begin : g_line_wide
    assign first_sat = LINE_BITS'(first_line_q);
  end else begin : g_line_narrow
    assign first_sat = (first_line_q[CFG_W-1:LINE_BITS] != '0) ? '1
                                                                : first_line_q[LINE_BITS-1:0];
  end

  function automatic logic [POSITION_BITS-1:0] pos_inc(logic [POSITION_BITS-1:0] v);
    return (v == '1) ? v : v + POS_ONE;
  endfunction

  function automatic token_kind_e word_kind(scan_mode_e m, logic [NUM_KW-1:0] c,
                                            logic [POSITION_BITS-1:0] len);
    token_kind_e k;
    k = KIND_IDENT;
    if (m == MODE_DIGITS || m == MODE_WORD_N) begin
      k = KIND_LITERAL;
    end else begin
      for (int unsigned i = 0; i < NUM_KW; i++) begin
        if (c[i] && (len == POSITION_BITS'(KW_LEN[i]))) begin
          k = KIND_KEYWORD;
        end
      end
    end
    return k;
  endfunction

  always_comb begin
    logic [1:0] n;
    logic       done;
    mode_d = mode_q;
    ws_d   = ws_q;
    wl_d   = wl_q;
    cand_d = cand_q;
    pm_d   = pm_q;
    n      = 2'd0;
    done   = 1'b0;
    for (int i = 0; i < TOK_PER_BYTE; i++) begin
      tok_kind_o[i]   = KIND_END;
      tok_start_o[i]  = '0;
      tok_length_o[i] = '0;
      tok_line_o[i]   = '0;
    end
    ln_d = (pos_q == '0) ? first_sat : ln_q;

    // a held minus resolves against this byte
    if (pm_q) begin
      pm_d = 1'b0;
      if (n != 2'd3) begin
        tok_kind_o[n]   = KIND_SYMBOL;
        tok_start_o[n]  = ws_q;
        tok_length_o[n] = (byte_i == CH_GT) ? POS_TWO : POS_ONE;
        tok_line_o[n]   = ln_d;
        n = n + 2'd1;
      end
      done = (byte_i == CH_GT);
    end

    if (!done && mode_q == MODE_DIGITS) begin
      if (is_digit(byte_i)) begin
        wl_d = pos_inc(wl_q);
        done = 1'b1;
      end else begin
        if (n != 2'd3) begin
          tok_kind_o[n]   = KIND_LITERAL;
          tok_start_o[n]  = ws_q;
          tok_length_o[n] = wl_q;
          tok_line_o[n]   = ln_d;
          n = n + 2'd1;
        end
        mode_d = MODE_IDLE;
      end
    end else if (!done && (mode_q == MODE_WORD || mode_q == MODE_WORD_N)) begin
      if (is_blank(byte_i) || is_sym(byte_i)) begin
        if (n != 2'd3) begin
          tok_kind_o[n]   = word_kind(mode_q, cand_q, wl_q);
          tok_start_o[n]  = ws_q;
          tok_length_o[n] = wl_q;
          tok_line_o[n]   = ln_d;
          n = n + 2'd1;
        end
        mode_d = MODE_IDLE;
      end else begin
        cand_d = narrow(cand_q, wl_q[3:0], |wl_q[POSITION_BITS-1:4], byte_i);
        wl_d   = pos_inc(wl_q);
        mode_d = MODE_WORD;
        done   = 1'b1;
      end
    end

    if (!done) begin
      if (is_blank(byte_i)) begin
        if (byte_i == CH_NL) begin
          ln_d = (ln_d == '1) ? ln_d : ln_d + LINE_BITS'(1);
        end
      end else if (byte_i == CH_MINUS) begin
        pm_d = 1'b1;
        ws_d = pos_q;
      end else if (is_sym(byte_i)) begin
        if (n != 2'd3) begin
          tok_kind_o[n]   = KIND_SYMBOL;
          tok_start_o[n]  = pos_q;
          tok_length_o[n] = POS_ONE;
          tok_line_o[n]   = ln_d;
          n = n + 2'd1;
        end
      end else begin
        mode_d = is_digit(byte_i) ? MODE_DIGITS :
                 ((byte_i == CH_N) ? MODE_WORD_N : MODE_WORD);
        ws_d   = pos_q;
        wl_d   = POS_ONE;
        cand_d = narrow('1, 4'd0, 1'b0, byte_i);
      end
    end

    pos_d = pos_inc(pos_q);

    // end of text flushes whatever is open, then the end marker
    if (last_i) begin
      if (pm_d) begin
        pm_d = 1'b0;
        if (n != 2'd3) begin
          tok_kind_o[n]   = KIND_SYMBOL;
          tok_start_o[n]  = ws_d;
          tok_length_o[n] = POS_ONE;
          tok_line_o[n]   = ln_d;
          n = n + 2'd1;
        end
      end
      if (mode_d != MODE_IDLE) begin
        if (n != 2'd3) begin
          tok_kind_o[n]   = word_kind(mode_d, cand_d, wl_d);
          tok_start_o[n]  = ws_d;
          tok_length_o[n] = wl_d;
          tok_line_o[n]   = ln_d;
          n = n + 2'd1;
        end
      end
      if (n != 2'd3) begin
        tok_kind_o[n]   = KIND_END;
        tok_start_o[n]  = pos_d;
        tok_length_o[n] = '0;
        tok_line_o[n]   = ln_d;
        n = n + 2'd1;
      end
      pos_d  = '0;
      mode_d = MODE_IDLE;
      cand_d = '1;
    end

    push_cnt_o = fire_i ? n : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_line_q <= FIRST_LINE_RST;
      mode_q       <= MODE_IDLE;
      ws_q         <= '0;
      wl_q         <= '0;
      cand_q       <= '1;
      pm_q         <= 1'b0;
      pos_q        <= '0;
      ln_q         <= LINE_BITS'(FIRST_LINE_RST);
    end else begin
      if (cfg_we_i) begin
        first_line_q <= cfg_data_i;
      end
      if (fire_i) begin
        mode_q <= mode_d;
        ws_q   <= ws_d;
        wl_q   <= wl_d;
        cand_q <= cand_d;
        pm_q   <= pm_d;
        pos_q  <= pos_d;
        ln_q   <= ln_d;
      end
    end
  end

endmodule

### sv/dtl_token_fifo.sv
// result queue: takes up to three tokens a cycle, hands out one a cycle while the output is ready
module dtl_token_fifo import dtl_pkg::*; #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned LINE_BITS     = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [1:0]               push_cnt_i,
  input  token_kind_e              tok_kind_i   [TOK_PER_BYTE],
  input  logic [POSITION_BITS-1:0] tok_start_i  [TOK_PER_BYTE],
  input  logic [POSITION_BITS-1:0] tok_length_i [TOK_PER_BYTE],
  input  logic [LINE_BITS-1:0]     tok_line_i   [TOK_PER_BYTE],
  output logic                     space_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               out_kind_o,
  output logic [POSITION_BITS-1:0] out_start_o,
  output logic [POSITION_BITS-1:0] out_length_o,
  output logic [LINE_BITS-1:0]     out_line_o,
  output logic                     out_last_o
);

  token_kind_e              mem_kind   [FIFO_DEPTH];
  logic [POSITION_BITS-1:0] mem_start  [FIFO_DEPTH];
  logic [POSITION_BITS-1:0] mem_length [FIFO_DEPTH];
  logic [LINE_BITS-1:0]     mem_line   [FIFO_DEPTH];
  logic                     mem_last   [FIFO_DEPTH];

  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  pop;

  // room for a full burst from one byte
  assign space_o     = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - TOK_PER_BYTE));
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;

  assign out_kind_o   = mem_kind[rd_ptr_q];
  assign out_start_o  = mem_start[rd_ptr_q];
  assign out_length_o = mem_length[rd_ptr_q];
  assign out_line_o   = mem_line[rd_ptr_q];
  assign out_last_o   = mem_last[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_cnt_i);
  assign rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(pop);
  assign cnt_d    = cnt_q + FIFO_CNT_W'(push_cnt_i) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TOK_PER_BYTE; i++) begin
      if (2'(i) < push_cnt_i) begin
        mem_kind[wr_ptr_q + FIFO_PTR_W'(i)]   <= tok_kind_i[i];
        mem_start[wr_ptr_q + FIFO_PTR_W'(i)]  <= tok_start_i[i];
        mem_length[wr_ptr_q + FIFO_PTR_W'(i)] <= tok_length_i[i];
        mem_line[wr_ptr_q + FIFO_PTR_W'(i)]   <= tok_line_i[i];
        mem_last[wr_ptr_q + FIFO_PTR_W'(i)]   <= (2'(i + 1) == push_cnt_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
